FILE: rtl/assert_macros.svh
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on the rising clock edge, disabled while reset is asserted.
`define ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("assertion failed");

// Condition that must never hold.
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
  `ASSERT_CLK(lbl, clk, rstn, !(cond))

`endif

FILE: rtl/upe_pkg.sv
// ----------------------------------------------------------------------------
// upe_pkg
// Types, constants and helpers for the URI percent encoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package upe_pkg;

  localparam int unsigned CP_W       = 21;
  localparam int unsigned CHAR_W     = 7;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [CHAR_W-1:0] CH_PERCENT    = 7'h25;
  localparam logic [CHAR_W-1:0] CH_DASH       = 7'h2D;
  localparam logic [CHAR_W-1:0] CH_PERIOD     = 7'h2E;
  localparam logic [CHAR_W-1:0] CH_UNDERSCORE = 7'h5F;
  localparam logic [CHAR_W-1:0] CH_TILDE      = 7'h7E;

  localparam logic [CP_W-1:0] CP_REPLACEMENT = 21'h00FFFD;
  localparam logic [CP_W-1:0] CP_SURR_LO     = 21'h00D800;
  localparam logic [CP_W-1:0] CP_SURR_HI     = 21'h00DFFF;
  localparam logic [CP_W-1:0] CP_MAX         = 21'h10FFFF;

  typedef enum logic [2:0] {
    PH_PCT = 3'b001,
    PH_HI  = 3'b010,
    PH_LO  = 3'b100
  } phase_e;

  // One classified word: a literal character or up to four UTF-8 bytes.
  typedef struct packed {
    logic            literal;
    logic [1:0]      last_idx;
    logic [3:0][7:0] bytes;
  } entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

  function automatic logic [CHAR_W-1:0] hex_digit(input logic [3:0] nib);
    logic [CHAR_W-1:0] wide;
    wide = {3'b000, nib};
    if (nib < 4'd10) begin
      hex_digit = 7'h30 + wide;
    end else begin
      hex_digit = 7'h37 + wide;
    end
  endfunction

endpackage

`default_nettype wire

FILE: rtl/upe_front.sv
// ----------------------------------------------------------------------------
// upe_front
// Classifies a code point and builds its literal or UTF-8 byte form.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module upe_front (
  input  wire logic [upe_pkg::CP_W-1:0] code_point_i,
  output upe_pkg::entry_t               entry_o
);

  logic                      unres;
  logic [upe_pkg::CP_W-1:0]  cp;
  logic [upe_pkg::CHAR_W-1:0] lo7;

  assign lo7 = code_point_i[upe_pkg::CHAR_W-1:0];

  always_comb begin
    unres = 1'b0;
    if (code_point_i[upe_pkg::CP_W-1:upe_pkg::CHAR_W] == '0) begin
      unres = (lo7 >= 7'h30 && lo7 <= 7'h39) ||
              (lo7 >= 7'h41 && lo7 <= 7'h5A) ||
              (lo7 >= 7'h61 && lo7 <= 7'h7A) ||
              lo7 == upe_pkg::CH_DASH || lo7 == upe_pkg::CH_UNDERSCORE ||
              lo7 == upe_pkg::CH_PERIOD || lo7 == upe_pkg::CH_TILDE;
    end
  end

  always_comb begin
    if ((code_point_i >= upe_pkg::CP_SURR_LO && code_point_i <= upe_pkg::CP_SURR_HI) ||
        code_point_i > upe_pkg::CP_MAX) begin
      cp = upe_pkg::CP_REPLACEMENT;
    end else begin
      cp = code_point_i;
    end
  end

  always_comb begin
    entry_o          = '0;
    entry_o.literal  = unres;
    if (unres || cp < 21'h80) begin
      entry_o.last_idx = 2'd0;
      entry_o.bytes[0] = {1'b0, cp[6:0]};
    end else if (cp < 21'h800) begin
      entry_o.last_idx = 2'd1;
      entry_o.bytes[0] = {3'b110, cp[10:6]};
      entry_o.bytes[1] = {2'b10, cp[5:0]};
    end else if (cp < 21'h10000) begin
      entry_o.last_idx = 2'd2;
      entry_o.bytes[0] = {4'b1110, cp[15:12]};
      entry_o.bytes[1] = {2'b10, cp[11:6]};
      entry_o.bytes[2] = {2'b10, cp[5:0]};
    end else begin
      entry_o.last_idx = 2'd3;
      entry_o.bytes[0] = {5'b11110, cp[20:18]};
      entry_o.bytes[1] = {2'b10, cp[17:12]};
      entry_o.bytes[2] = {2'b10, cp[11:6]};
      entry_o.bytes[3] = {2'b10, cp[5:0]};
    end
  end

endmodule

`default_nettype wire

FILE: rtl/upe_queue.sv
// ----------------------------------------------------------------------------
// upe_queue
// Short FIFO between the classifier and the serialiser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module upe_queue #(
  parameter int unsigned DEPTH = upe_pkg::QUEUE_DEPTH
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  upe_pkg::entry_t     wr_entry_i,
  input  wire logic           pop_i,
  output upe_pkg::entry_t     head_o,
  output upe_pkg::q_status_t  status_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  upe_pkg::entry_t slots_q [DEPTH];
  logic [PW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]   count_q, count_d;
  logic            do_push, do_pop;

  assign status_o.empty = (count_q == '0);
  assign status_o.full  = (count_q == CW'(DEPTH));
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign head_o         = slots_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= wr_entry_i;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/upe_back.sv
// ----------------------------------------------------------------------------
// upe_back
// Serialises the head word into output characters, one per cycle while the queue is not empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module upe_back (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  upe_pkg::entry_t                 head_i,
  input  upe_pkg::q_status_t              status_i,
  output logic                            pop_o,
  output logic                            out_valid_o,
  output logic [upe_pkg::CHAR_W-1:0]      out_char_o,
  output logic                            last_of_run_o
);

  upe_pkg::phase_e             phase_q, phase_d;
  logic [1:0]                  byte_q, byte_d;
  logic                        emit, last;
  logic [upe_pkg::CHAR_W-1:0]  ch;
  logic [7:0]                  cur;
  logic                        valid_q;
  logic [upe_pkg::CHAR_W-1:0]  char_q;
  logic                        last_q;

  assign emit = !status_i.empty;
  assign cur  = head_i.bytes[byte_q];

  always_comb begin
    ch   = upe_pkg::CH_PERCENT;
    last = 1'b0;
    if (head_i.literal) begin
      ch   = cur[upe_pkg::CHAR_W-1:0];
      last = 1'b1;
    end else begin
      case (phase_q)
        upe_pkg::PH_PCT: ch = upe_pkg::CH_PERCENT;
        upe_pkg::PH_HI:  ch = upe_pkg::hex_digit(cur[7:4]);
        upe_pkg::PH_LO: begin
          ch   = upe_pkg::hex_digit(cur[3:0]);
          last = (byte_q == head_i.last_idx);
        end
        default:         ch = upe_pkg::CH_PERCENT;
      endcase
    end
  end

  assign pop_o = emit && last;

  always_comb begin
    phase_d = phase_q;
    byte_d  = byte_q;
    if (emit) begin
      if (last) begin
        phase_d = upe_pkg::PH_PCT;
        byte_d  = 2'd0;
      end else begin
        case (phase_q)
          upe_pkg::PH_PCT: phase_d = upe_pkg::PH_HI;
          upe_pkg::PH_HI:  phase_d = upe_pkg::PH_LO;
          upe_pkg::PH_LO: begin
            phase_d = upe_pkg::PH_PCT;
            byte_d  = byte_q + 2'd1;
          end
          default:         phase_d = upe_pkg::PH_PCT;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= upe_pkg::PH_PCT;
      byte_q  <= 2'd0;
      valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      byte_q  <= byte_d;
      valid_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    char_q <= ch;
    last_q <= last;
  end

  assign out_valid_o   = valid_q;
  assign out_char_o    = char_q;
  assign last_of_run_o = last_q;

endmodule

`default_nettype wire

FILE: rtl/uri_percent_encoder_core.sv
// ----------------------------------------------------------------------------
// uri_percent_encoder_core
// Percent-encodes one Unicode code point per word for a URI component.
// ----------------------------------------------------------------------------
// Input: a code point is taken at a rising edge with start high and busy low.
// Unreserved ASCII (letters, digits, - _ . ~) comes out as one character;
// anything else goes out as %XX triplets of its UTF-8 bytes (3, 6, 9 or 12
// characters). Surrogates and values above U+10FFFF become %EF%BF%BD.
// Output: one character per cycle on out_char_o while a word is queued, marked by out_valid_o for
// exactly one cycle; last_of_run_o flags the final character of a word.
// An accepted word is written into the queue, and each of its characters is
// registered in the serialiser's output registers before it reaches the outputs.
// Throughput: one output character per cycle while a word is queued, set by
// the serialiser, which takes the next queued word as soon as the last character
// of a word is emitted, so single-character words sustain one word per cycle.
// A short queue (DEPTH words) sits between classifier and serialiser; busy
// is high while it is full.
// Reset clears the queue and serialiser; out_valid_o stays low until a word
// is taken. The receiver cannot stall the output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module uri_percent_encoder_core #(
  parameter int unsigned DEPTH = upe_pkg::QUEUE_DEPTH
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [upe_pkg::CP_W-1:0]     code_point_i,
  output logic                              out_valid_o,
  output logic [upe_pkg::CHAR_W-1:0]        out_char_o,
  output logic                              last_of_run_o
);

  upe_pkg::entry_t    new_entry, head;
  upe_pkg::q_status_t q_status;
  logic               pop;
  logic               accept;

  assign busy   = q_status.full;
  assign accept = start && !busy;

  upe_front u_front (
    .code_point_i (code_point_i),
    .entry_o      (new_entry)
  );

  upe_queue #(
    .DEPTH (DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (accept),
    .wr_entry_i (new_entry),
    .pop_i      (pop),
    .head_o     (head),
    .status_o   (q_status)
  );

  upe_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .status_i      (q_status),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_char_o    (out_char_o),
    .last_of_run_o (last_of_run_o)
  );

  `ASSERT_CLK(a_accept_fills, clk_i, rst_ni, accept |=> !q_status.empty)
  `ASSERT_CLK(a_run_unbroken, clk_i, rst_ni, (out_valid_o && !last_of_run_o) |=> out_valid_o)
  `ASSERT_NEVER(a_no_pct_last, clk_i, rst_ni,
                out_valid_o && last_of_run_o && out_char_o == upe_pkg::CH_PERCENT)
  `ASSERT_CLK(a_busy_nonempty, clk_i, rst_ni, busy |-> !q_status.empty)

endmodule

`default_nettype wire

FILE: bench/uri_percent_encoder_core_test.sv
// ----------------------------------------------------------------------------
// uri_percent_encoder_core_test
// Drives code points into the percent encoder and checks every output
// character and end-of-run flag against a local encoding predictor.
// Directed words cover literals, reserved ASCII, the UTF-8 length bounds and
// the replacement cases. A weighted random stream with random sender gaps
// and gap-free bursts follows.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module uri_percent_encoder_core_test;

  localparam int unsigned CP_W         = upe_pkg::CP_W;
  localparam int unsigned CHAR_W       = upe_pkg::CHAR_W;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned RANDOM_WORDS = 270;

  typedef struct packed {
    logic [CHAR_W-1:0] ch_code;
    logic              last_flag;
  } enc_char_t;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              start;
  logic              busy;
  logic [CP_W-1:0]   code_point_i;
  logic              out_valid_o;
  logic [CHAR_W-1:0] out_char_o;
  logic              last_of_run_o;

  enc_char_t   pending_chars[$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;
  bit          burst_mode     = 1'b0;

  uri_percent_encoder_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .code_point_i (code_point_i),
    .out_valid_o  (out_valid_o),
    .out_char_o   (out_char_o),
    .last_of_run_o(last_of_run_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic bit is_literal(input logic [CP_W-1:0] cp);
    return (cp >= 21'h30 && cp <= 21'h39) || (cp >= 21'h41 && cp <= 21'h5A) ||
           (cp >= 21'h61 && cp <= 21'h7A) || cp == upe_pkg::CH_DASH ||
           cp == upe_pkg::CH_PERIOD || cp == upe_pkg::CH_UNDERSCORE ||
           cp == upe_pkg::CH_TILDE;
  endfunction

  function automatic logic [CHAR_W-1:0] nibble_char(input logic [3:0] nib);
    if (nib < 4'd10) begin
      return 7'h30 + CHAR_W'(nib);
    end else begin
      return 7'h41 + CHAR_W'(nib) - 7'd10;
    end
  endfunction

  // Appends the characters one code point should produce.
  function automatic void encode_code_point(input logic [CP_W-1:0] cp);
    logic [CP_W-1:0] val;
    logic [7:0]      utf [4];
    int              nbytes;
    if (is_literal(cp)) begin
      pending_chars.push_back('{ch_code: cp[CHAR_W-1:0], last_flag: 1'b1});
      return;
    end
    val = cp;
    if ((cp >= upe_pkg::CP_SURR_LO && cp <= upe_pkg::CP_SURR_HI) ||
        cp > upe_pkg::CP_MAX) begin
      val = upe_pkg::CP_REPLACEMENT;
    end
    if (val < 21'h80) begin
      nbytes  = 1;
      utf[0]  = val[7:0];
    end else if (val < 21'h800) begin
      nbytes  = 2;
      utf[0]  = {3'b110, val[10:6]};
      utf[1]  = {2'b10, val[5:0]};
    end else if (val < 21'h10000) begin
      nbytes  = 3;
      utf[0]  = {4'b1110, val[15:12]};
      utf[1]  = {2'b10, val[11:6]};
      utf[2]  = {2'b10, val[5:0]};
    end else begin
      nbytes  = 4;
      utf[0]  = {5'b11110, val[20:18]};
      utf[1]  = {2'b10, val[17:12]};
      utf[2]  = {2'b10, val[11:6]};
      utf[3]  = {2'b10, val[5:0]};
    end
    for (int i = 0; i < nbytes; i++) begin
      pending_chars.push_back('{ch_code: upe_pkg::CH_PERCENT, last_flag: 1'b0});
      pending_chars.push_back('{ch_code: nibble_char(utf[i][7:4]), last_flag: 1'b0});
      pending_chars.push_back('{ch_code: nibble_char(utf[i][3:0]),
                                last_flag: (i == nbytes - 1)});
    end
  endfunction

  function automatic int unsigned sender_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (burst_mode || r < 50) begin
      return 0;
    end else if (r < 85) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 8);
    end else begin
      return $urandom_range(20, 40);
    end
  endfunction

  // Called at a rising edge; leaves start high when no gap follows.
  task automatic send_word(input logic [CP_W-1:0] cp);
    int unsigned gap;
    start        <= 1'b1;
    code_point_i <= cp;
    do @(posedge clk_i); while (busy);
    encode_code_point(cp);
    gap = sender_gap();
    if (gap != 0) begin
      start        <= 1'b0;
      code_point_i <= CP_W'($urandom());
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    enc_char_t exp_char;
    if (rst_ni && out_valid_o) begin
      if (pending_chars.size() == 0) begin
        $error("unexpected word: out_char %h last_of_run %b", out_char_o, last_of_run_o);
        mismatch_count++;
      end else begin
        exp_char = pending_chars.pop_front();
        if (out_char_o !== exp_char.ch_code) begin
          $error("out_char: expected %h, got %h", exp_char.ch_code, out_char_o);
          mismatch_count++;
        end
        if (last_of_run_o !== exp_char.last_flag) begin
          $error("last_of_run: expected %b, got %b", exp_char.last_flag, last_of_run_o);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic test_literals();
    send_word(21'h30);
    send_word(21'h39);
    send_word(21'h41);
    send_word(21'h7A);
    send_word(CP_W'(upe_pkg::CH_DASH));
    send_word(CP_W'(upe_pkg::CH_UNDERSCORE));
    send_word(CP_W'(upe_pkg::CH_PERIOD));
    send_word(CP_W'(upe_pkg::CH_TILDE));
  endtask

  task automatic test_reserved_ascii();
    send_word(21'h00);
    send_word(21'h2F);
    send_word(21'h3A);
    send_word(21'h60);
    send_word(21'h7B);
    send_word(21'h7F);
  endtask

  task automatic test_utf8_bounds();
    send_word(21'h80);
    send_word(21'h7FF);
    send_word(21'h800);
    send_word(21'hFFFF);
    send_word(21'h10000);
    send_word(upe_pkg::CP_MAX);
  endtask

  task automatic test_replacement();
    send_word(upe_pkg::CP_SURR_LO);
    send_word(upe_pkg::CP_SURR_HI);
    send_word(upe_pkg::CP_MAX + 21'd1);
    send_word(21'h1FFFFF);
  endtask

  task automatic test_random_stream();
    int unsigned     r;
    logic [CP_W-1:0] cp;
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 30 == 0) begin
        burst_mode = ($urandom_range(0, 2) == 0);
      end
      if (n == RANDOM_WORDS / 2) begin
        wait_drained();
      end
      r = $urandom_range(0, 99);
      if (r < 20) begin
        do cp = CP_W'($urandom_range(0, 127)); while (!is_literal(cp));
      end else if (r < 35) begin
        cp = CP_W'($urandom_range(0, 127));
      end else if (r < 50) begin
        cp = CP_W'($urandom_range(21'h80, 21'h7FF));
      end else if (r < 65) begin
        cp = CP_W'($urandom_range(21'h800, 21'hFFFF));
      end else if (r < 72) begin
        cp = CP_W'($urandom_range(upe_pkg::CP_SURR_LO, upe_pkg::CP_SURR_HI));
      end else if (r < 87) begin
        cp = CP_W'($urandom_range(21'h10000, upe_pkg::CP_MAX));
      end else begin
        cp = CP_W'($urandom_range(0, 21'h1FFFFF));
      end
      send_word(cp);
    end
    burst_mode = 1'b0;
  endtask

  initial begin
    rst_ni       = 1'b0;
    start        = 1'b0;
    code_point_i = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_literals();
    test_reserved_ascii();
    wait_drained();
    test_utf8_bounds();
    test_replacement();
    test_random_stream();

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
